FILE: src/btt_pkg.sv
package btt_pkg;

  localparam int unsigned DEF_MAX_LEVEL = 64;
  localparam int unsigned DEF_FRAC_BITS = 16;

  // tess_level register
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned LEVEL_RST = 4;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS = 8;

  // numerator slots, one division each per triangle
  localparam int unsigned NUM_SLOTS = 6;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned SLOT_U    = 0;
  localparam int unsigned SLOT_V    = 1;
  localparam int unsigned SLOT_W0   = 2;
  localparam int unsigned SLOT_UM1  = 3;
  localparam int unsigned SLOT_WP1  = 4;
  localparam int unsigned SLOT_VADJ = 5;  // v+1 upright, v-1 inverted

  typedef struct packed {
    logic              accept;
    logic              div_start;
    logic              emit;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: src/btt_div.sv
module btt_div #(
  parameter int unsigned LW        = 7,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LW-1:0]        numer_i,
  input  logic [LW-1:0]        denom_i,
  output logic [FRAC_BITS:0]   quo_o,
  output logic                 done_o
);
  import btt_pkg::*;

  localparam int unsigned NITER = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned CW    = (NITER > 1) ? $clog2(NITER) : 1;

  logic [LW-1:0]        r_q, r_n;
  logic [FRAC_BITS-1:0] frac_q, frac_n;
  logic                 top_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [LW:0]          r2;
  logic                 bitv;
  logic                 last_iter;

  assign last_iter = (cnt_q == CW'(NITER - 1));

  // numerator never exceeds the level, so only the integer bit is special
  always_comb begin
    r_n    = r_q;
    frac_n = frac_q;
    r2     = '0;
    bitv   = 1'b0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (int'(cnt_q) * DIV_STEPS + j < FRAC_BITS) begin
        r2 = {r_n, 1'b0};
        if (r2 >= {1'b0, denom_i}) begin
          r2   = r2 - {1'b0, denom_i};
          bitv = 1'b1;
        end else begin
          bitv = 1'b0;
        end
        r_n    = r2[LW-1:0];
        frac_n = {frac_n[FRAC_BITS-2:0], bitv};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_iter;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last_iter) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      top_q  <= (numer_i == denom_i);
      r_q    <= (numer_i == denom_i) ? '0 : numer_i;
      frac_q <= '0;
    end else if (busy_q) begin
      r_q    <= r_n;
      frac_q <= frac_n;
    end
  end

  assign quo_o  = {top_q, frac_q};
  assign done_o = done_q;

endmodule

FILE: src/btt_datapath.sv
module btt_datapath #(
  parameter int unsigned MAX_LEVEL = 64,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DATA_W    = 160
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [btt_pkg::LEVEL_W-1:0] cfg_wdata_i,
  input  logic                        restart_i,
  input  btt_pkg::cmd_t               cmd_i,
  output btt_pkg::sts_t               sts_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [DATA_W-1:0]           m_data_o,
  output logic                        m_user_o,
  output logic                        m_last_o
);
  import btt_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LEVEL + 1);
  localparam int unsigned CLW = LW + 1;
  localparam int unsigned CB  = FRAC_BITS + 1;

  function automatic logic [LW-1:0] eff_level(logic [LEVEL_W-1:0] lvl);
    logic [7:0] l8;
    logic [7:0] m8;
    l8 = {1'b0, lvl};
    m8 = 8'(MAX_LEVEL);
    if (l8 == 8'd0) begin
      l8 = 8'd1;
    end else if (l8 > m8) begin
      l8 = m8;
    end
    return l8[LW-1:0];
  endfunction

  localparam logic [LW-1:0] RST_Q = eff_level(LEVEL_W'(LEVEL_RST));

  logic [LEVEL_W-1:0] level_q;
  logic [LW-1:0]      q_eff, q_new;
  logic [LW-1:0]      row_q, u_q, w_q;
  logic [CLW-1:0]     col_q;
  logic [LW-1:0]      v;
  logic               even;
  logic               end_row;
  logic               last_tri;
  logic [LW-1:0]      num [NUM_SLOTS];
  logic [CB-1:0]      quo_q [NUM_SLOTS];
  logic [CB-1:0]      div_quo;
  logic               div_done;
  logic               m_valid_q;
  logic [9*CB-1:0]    coords;

  assign q_eff    = eff_level(level_q);
  assign q_new    = eff_level(cfg_wdata_i);
  assign v        = q_eff - u_q - w_q;
  assign even     = ~col_q[0];
  assign end_row  = (col_q == ({row_q, 1'b0} - CLW'(2)));
  assign last_tri = (row_q == LW'(1)) && (col_q == '0);

  always_comb begin
    num[SLOT_U]    = u_q;
    num[SLOT_V]    = v;
    num[SLOT_W0]   = w_q;
    num[SLOT_UM1]  = u_q - LW'(1);
    num[SLOT_WP1]  = w_q + LW'(1);
    num[SLOT_VADJ] = even ? (v + LW'(1)) : (v - LW'(1));
  end

  btt_div #(
    .LW       (LW),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .numer_i(num[cmd_i.slot]),
    .denom_i(q_eff),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      quo_q[cmd_i.slot] <= div_quo;
    end
  end

  // patch walk: config and restart both reload the first triangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_W'(LEVEL_RST);
      row_q   <= RST_Q;
      u_q     <= RST_Q;
      w_q     <= '0;
      col_q   <= '0;
    end else if (cfg_we_i) begin
      level_q <= cfg_wdata_i;
      row_q   <= q_new;
      u_q     <= q_new;
      w_q     <= '0;
      col_q   <= '0;
    end else if (cmd_i.accept && restart_i) begin
      row_q <= q_eff;
      u_q   <= q_eff;
      w_q   <= '0;
      col_q <= '0;
    end else if (cmd_i.emit) begin
      if (end_row) begin
        if (row_q == LW'(1)) begin
          row_q <= q_eff;
          u_q   <= q_eff;
          w_q   <= '0;
        end else begin
          row_q <= row_q - LW'(1);
          u_q   <= row_q - LW'(1);
          w_q   <= w_q + LW'(1);
        end
        col_q <= '0;
      end else begin
        if (even) begin
          u_q <= u_q - LW'(1);
        end
        col_q <= col_q + CLW'(1);
      end
    end
  end

  always_comb begin
    coords[0*CB +: CB] = quo_q[SLOT_U];
    coords[1*CB +: CB] = quo_q[SLOT_V];
    coords[2*CB +: CB] = quo_q[SLOT_W0];
    if (even) begin
      coords[3*CB +: CB] = quo_q[SLOT_UM1];
      coords[4*CB +: CB] = quo_q[SLOT_VADJ];
      coords[5*CB +: CB] = quo_q[SLOT_W0];
      coords[6*CB +: CB] = quo_q[SLOT_UM1];
      coords[7*CB +: CB] = quo_q[SLOT_V];
      coords[8*CB +: CB] = quo_q[SLOT_WP1];
    end else begin
      coords[3*CB +: CB] = quo_q[SLOT_UM1];
      coords[4*CB +: CB] = quo_q[SLOT_V];
      coords[5*CB +: CB] = quo_q[SLOT_WP1];
      coords[6*CB +: CB] = quo_q[SLOT_U];
      coords[7*CB +: CB] = quo_q[SLOT_VADJ];
      coords[8*CB +: CB] = quo_q[SLOT_WP1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_o <= DATA_W'(coords);
      m_user_o <= even;
      m_last_o <= last_tri;
    end
  end

  assign m_valid_o       = m_valid_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

`ifndef SYNTHESIS
  a_row_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != '0) && (u_q <= row_q))
    else $error("row or u count out of range");

  a_w_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, w_q} + {1'b0, row_q}) == {1'b0, q_eff})
    else $error("w count does not match row");

  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < {row_q, 1'b0})
    else $error("column index past end of row");
`endif

endmodule

FILE: src/btt_ctrl.sv
module btt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  btt_pkg::sts_t sts_i,
  output btt_pkg::cmd_t cmd_o
);
  import btt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              last_slot;

  assign last_slot = (slot_q == SLOT_W'(NUM_SLOTS - 1));

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_LOAD;
          slot_d  = '0;
        end
      end
      ST_LOAD: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.div_done) begin
          if (last_slot) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_LOAD;
            slot_d  = slot_q + SLOT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  assign s_ready_o        = (state_q == ST_IDLE);
  assign cmd_o.accept     = (state_q == ST_IDLE) && s_valid_i;
  assign cmd_o.div_start  = (state_q == ST_LOAD);
  assign cmd_o.emit       = (state_q == ST_EMIT) && sts_i.out_free;
  assign cmd_o.slot       = slot_q;

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.div_done)
    else $error("divider finished while idle");

  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !sts_i.div_done)
    else $error("divider finished one cycle after start");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_LOAD) && (slot_q == '0))
    else $error("accepted beat did not start at first slot");
`endif

endmodule

FILE: src/barycentric_triangle_tessellator_unit.sv
// Uniform triangle-domain tessellator.
// Slave stream: each beat is one request; tdata[0] = restart begins the patch
// again at its first triangle. Master stream: one triangle per request, three
// barycentric vertices n/q in unsigned fixed point (FRAC_BITS fraction bits,
// floored); tuser = upright, tlast = last triangle of the patch. The walk
// wraps to the first triangle after the last one.
// cfg_we_i writes tess_level (0 acts as 1, above MAX_LEVEL clamps) and
// restarts the patch; write only while no request is in flight.
// Datapath: six divisions by the level per triangle, sharing one iterative
// divider that resolves 8 quotient bits a cycle; one request is in flight at
// a time. The output register lets the next request be accepted while a
// result waits; a stalled receiver holds the finished triangle in the last
// state until the register frees, and tready stays low meanwhile.
// Reset: level 4, patch at its first triangle, no result pending.
module barycentric_triangle_tessellator_unit #(
  parameter int unsigned MAX_LEVEL = btt_pkg::DEF_MAX_LEVEL,
  parameter int unsigned FRAC_BITS = btt_pkg::DEF_FRAC_BITS,
  parameter int unsigned DATA_W    = ((9 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [btt_pkg::LEVEL_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [0] restart
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // first_u, first_v, first_w, second_u, second_v, second_w,
  // third_u, third_v, third_w, each FRAC_BITS+1 bits, zero pad on top
  output logic [DATA_W-1:0]           m_axis_tdata,
  output logic                        m_axis_tuser,   // upright
  output logic                        m_axis_tlast    // last_in_patch
);
  import btt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  btt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  btt_datapath #(
    .MAX_LEVEL(MAX_LEVEL),
    .FRAC_BITS(FRAC_BITS),
    .DATA_W   (DATA_W)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .restart_i  (s_axis_tdata[0]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser),
    .m_last_o   (m_axis_tlast)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import btt_pkg::*;

  localparam int unsigned COORD_W    = DEF_FRAC_BITS + 1;
  localparam int unsigned DATA_W     = ((9 * COORD_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [8:0][COORD_W-1:0] coord;  // first_u .. third_w
    logic                    upright;
    logic                    last;
  } triangle_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LEVEL_W-1:0] cfg_wdata = '0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [7:0]         s_data = '0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [DATA_W-1:0]  m_data;
  logic               m_upright;
  logic               m_last;

  barycentric_triangle_tessellator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_upright),
    .m_axis_tlast (m_last)
  );

  string coord_names [9] = '{"first_u", "first_v", "first_w", "second_u", "second_v",
                             "second_w", "third_u", "third_v", "third_w"};

  // patch walker state, mirrors the block
  logic [LEVEL_W-1:0] level_reg = LEVEL_W'(LEVEL_RST);
  logic [6:0]         row_len;
  logic [7:0]         col_idx;
  logic [6:0]         u_cnt;
  logic [6:0]         w_cnt;

  bit                 restart_queue [$];
  triangle_t          triangle_fifo [$];
  int unsigned        error_count = 0;
  int unsigned        triangles_seen = 0;
  int unsigned        cycle_count = 0;

  function automatic int unsigned active_level();
    int unsigned q;
    q = level_reg;
    if (q == 0) q = 1;
    if (q > DEF_MAX_LEVEL) q = DEF_MAX_LEVEL;
    return q;
  endfunction

  function automatic void begin_patch();
    int unsigned q;
    q = active_level();
    row_len = 7'(q);
    col_idx = '0;
    u_cnt   = 7'(q);
    w_cnt   = '0;
  endfunction

  function automatic logic [COORD_W-1:0] frac_of(int unsigned n, int unsigned q);
    longint unsigned t;
    t = n;
    t = (t << DEF_FRAC_BITS) / q;
    return t[COORD_W-1:0];
  endfunction

  function automatic triangle_t next_triangle(bit restart);
    int unsigned q, u, v, w, rl;
    bit          even;
    triangle_t   t;
    q = active_level();
    if (restart) begin_patch();
    rl = row_len;
    if (rl == 0 || rl > q || u_cnt > row_len || w_cnt != q - rl ||
        col_idx >= 2 * rl - 1 || u_cnt == 0) begin
      begin_patch();
      rl = row_len;
    end
    u = u_cnt;
    w = w_cnt;
    v = q - u - w;
    even = ~col_idx[0];
    t.coord[0] = frac_of(u, q);
    t.coord[1] = frac_of(v, q);
    t.coord[2] = frac_of(w, q);
    if (even) begin
      t.coord[3] = frac_of(u - 1, q);
      t.coord[4] = frac_of(v + 1, q);
      t.coord[5] = frac_of(w, q);
      t.coord[6] = frac_of(u - 1, q);
      t.coord[7] = frac_of(v, q);
      t.coord[8] = frac_of(w + 1, q);
    end else begin
      t.coord[3] = frac_of(u - 1, q);
      t.coord[4] = frac_of(v, q);
      t.coord[5] = frac_of(w + 1, q);
      t.coord[6] = frac_of(u, q);
      t.coord[7] = frac_of(v - 1, q);
      t.coord[8] = frac_of(w + 1, q);
    end
    t.upright = even;
    t.last    = (rl == 1 && col_idx == 0);
    // advance along the row, drop to the next row at its end
    if (even) u_cnt = u_cnt - 7'd1;
    col_idx = col_idx + 8'd1;
    if (col_idx >= 2 * rl - 1) begin
      row_len = row_len - 7'd1;
      if (row_len == 0) begin
        begin_patch();
      end else begin
        col_idx = '0;
        u_cnt   = row_len;
        w_cnt   = 7'(q - row_len);
      end
    end
    return t;
  endfunction

  function automatic void add_request(bit restart);
    restart_queue = {restart_queue, restart};
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // request driver: bursts with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (s_valid && s_ready) triangle_fifo = {triangle_fifo, next_triangle(s_data[0])};
    if (!s_valid || s_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (restart_queue.size() == 0) begin
        s_valid <= 1'b0;
      end else begin
        s_valid <= 1'b1;
        s_data  <= {7'b0, restart_queue.pop_front()};
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // result monitor with its own stall pattern and one long hold-off
  int unsigned hold_left = 0;
  int unsigned seg_left = 0;
  int unsigned stall_pct = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i) begin : monitor
    triangle_t want;
    if (m_valid && m_ready) begin
      triangles_seen++;
      if (triangle_fifo.size() == 0) begin
        $error("triangle beat with nothing outstanding");
        error_count++;
      end else begin
        want = triangle_fifo.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_data[i*COORD_W +: COORD_W] !== want.coord[i]) begin
            $error("%s: expected %0d, got %0d", coord_names[i], want.coord[i],
                   m_data[i*COORD_W +: COORD_W]);
            error_count++;
          end
        end
        if (m_upright !== want.upright) begin
          $error("upright: expected %0d, got %0d", want.upright, m_upright);
          error_count++;
        end
        if (m_last !== want.last) begin
          $error("last_in_patch: expected %0d, got %0d", want.last, m_last);
          error_count++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!long_hold_done && triangles_seen == 60) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      m_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        seg_left--;
      end
      m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_level(input logic [LEVEL_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    level_reg = value;
    begin_patch();
    cfg_we <= 1'b0;
  endtask

  // checked mid-cycle so the driver's updates at the edge have settled
  task automatic drain();
    while (restart_queue.size() != 0 || s_valid || triangle_fifo.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [LEVEL_W-1:0] lvl;
    int unsigned        n_items;
    begin_patch();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset level: one whole patch, wrap, then a restart mid-patch
    repeat (17) add_request(1'b0);
    add_request(1'b1);
    add_request(1'b0);
    drain();
    // zero acts as level 1; write lands mid-patch
    write_level(7'd0);
    repeat (3) add_request(1'b0);
    drain();
    // above the maximum clamps
    write_level(7'd65);
    repeat (2) add_request(1'b0);
    drain();
    write_level(7'd127);
    add_request(1'b1);
    add_request(1'b0);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: lvl = 7'd1;
        1: lvl = 7'd2;
        2: lvl = 7'd3;
        3: lvl = 7'(DEF_MAX_LEVEL);
        default:
          lvl = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 12))
                                            : 7'($urandom_range(0, 127));
      endcase
      write_level(lvl);
      n_items = $urandom_range(140, 180);
      repeat (n_items) add_request($urandom_range(0, 39) == 0);
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
